FILE: hdl/rc_expo_curve_point_macros.svh
// Assertion macros used by the rc_expo_curve_point port checker
`ifndef RC_EXPO_CURVE_POINT_MACROS_SVH
`define RC_EXPO_CURVE_POINT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RCX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rcx_pkg.sv
// Types and constants for the rc_expo_curve_point block
`timescale 1ns / 1ps

package rcx_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int NUM_STAGES  = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STICK_EXPO       = 3'd0,
        CFG_STICK_RATE       = 3'd1,
        CFG_THROTTLE_MIDDLE  = 3'd2,
        CFG_THROTTLE_EXPO    = 3'd3,
        CFG_THROTTLE_FLOOR   = 3'd4,
        CFG_THROTTLE_CEILING = 3'd5
    } cfg_index_t;

    typedef enum logic {
        REQ_PITCH_ROLL = 1'b0,
        REQ_THROTTLE   = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [6:0]  stick_expo;
        logic [7:0]  stick_rate;
        logic [6:0]  throttle_middle;
        logic [6:0]  throttle_expo;
        logic [11:0] throttle_floor;
        logic [11:0] throttle_ceiling;
    } cfg_t;

    localparam logic [6:0]  RST_STICK_EXPO       = 7'd65;
    localparam logic [7:0]  RST_STICK_RATE       = 8'd90;
    localparam logic [6:0]  RST_THROTTLE_MIDDLE  = 7'd50;
    localparam logic [6:0]  RST_THROTTLE_EXPO    = 7'd0;
    localparam logic [11:0] RST_THROTTLE_FLOOR   = 12'd1150;
    localparam logic [11:0] RST_THROTTLE_CEILING = 12'd1850;

    localparam logic [3:0] PITCH_LAST    = 4'd5;
    localparam logic [3:0] THROTTLE_LAST = 4'd10;

    // reciprocals: x/2500 = (x*R)>>33 for x < 2^22, x/10 = (x*R)>>17 for x < 2^14,
    // x/1000 = (x*R)>>34 for x < 2^24
    localparam logic [21:0] RECIP_2500 = 22'd3435974;
    localparam logic [13:0] RECIP_10   = 14'd13108;
    localparam logic [24:0] RECIP_1000 = 25'd17179870;

    localparam logic [11:0] VALUE_MAX = 12'd4095;

endpackage

FILE: hdl/rcx_pipe.sv
// Eleven-stage datapath that evaluates one curve breakpoint per transfer
`timescale 1ns / 1ps

module rcx_pipe
    import rcx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [3:0]  point_index,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [11:0] curve_value,
    output logic        index_error
);

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    logic              typ_reg [0:LAST-1];
    logic              err_reg [0:LAST];

    // stage 0
    logic signed [13:0] base_reg, base_next;
    logic [2:0]         i3_reg;
    logic signed [8:0]  t_reg [0:4];
    logic signed [8:0]  t_next;
    logic [6:0]         y_reg, y_next;
    logic               err_next;
    // stage 1
    logic signed [16:0] pb_reg, pb_next;
    logic [15:0]        tt_reg, tt_next;
    logic [13:0]        yy_reg [1:3];
    logic [13:0]        yy_next;
    // stage 2
    logic signed [25:0] p_reg, p_next;
    logic [22:0]        num_reg, num_next;
    // stage 3
    logic               ppos_reg;
    logic [43:0]        pm_reg, pm_next;
    logic [22:0]        rem_reg, rem_next;
    logic [6:0]         qhi_reg, qhi_next;
    // stage 4
    logic [10:0]        pv_reg [4:9];
    logic [10:0]        pv_next;
    logic [6:0]         q_reg, q_next;
    // stage 5
    logic signed [17:0] x_reg, x_next;
    // stage 6
    logic               xneg_reg;
    logic [27:0]        xm_reg, xm_next;
    // stage 7
    logic signed [12:0] v_reg, v_next;
    // stage 8
    logic signed [25:0] w_reg, w_next;
    // stage 9
    logic               wneg_reg;
    logic [48:0]        wm_reg, wm_next;
    // stage 10
    logic [11:0]        curve_reg, curve_next;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        adv[LAST] = !vld_reg[LAST] || !rsp_stall;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = {vld_reg[LAST-1:0], req_valid};
    end

    assign req_stall   = !adv[0];
    assign rsp_valid   = vld_reg[LAST];
    assign curve_value = curve_reg;
    assign index_error = err_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // stage 0: expo base, throttle offset and divisor root
    always_comb
    begin
        logic [5:0]         sq;
        logic signed [6:0]  dsq;
        logic signed [14:0] expo_prod;
        logic [7:0]         ten_i;
        sq        = 6'(point_index[2:0] * point_index[2:0]);
        dsq       = $signed({1'b0, sq}) - 7'sd25;
        expo_prod = $signed({1'b0, cfg.stick_expo}) * dsq;
        base_next = 14'(15'sd2500 + expo_prod);
        ten_i     = 8'(point_index * 8'd10);
        t_next    = $signed({1'b0, ten_i}) - $signed({2'b0, cfg.throttle_middle});
        if (t_next > 9'sd0)
        begin
            y_next = 7'd100 - cfg.throttle_middle;
        end
        else if (t_next < 9'sd0)
        begin
            y_next = cfg.throttle_middle;
        end
        else
        begin
            y_next = 7'd1;
        end
        if (req_type_t'(req_type) == REQ_THROTTLE)
        begin
            err_next = point_index > THROTTLE_LAST;
        end
        else
        begin
            err_next = point_index > PITCH_LAST;
        end
    end

    // stage 1: base times index, squares
    always_comb
    begin
        logic [8:0] at;
        pb_next = base_reg * $signed({1'b0, i3_reg});
        at      = (t_reg[0] < 9'sd0) ? 9'(-t_reg[0]) : t_reg[0];
        tt_next = at[7:0] * at[7:0];
        yy_next = y_reg * y_reg;
    end

    // stage 2: rate and expo products
    always_comb
    begin
        p_next   = pb_reg * $signed({1'b0, cfg.stick_rate});
        num_next = cfg.throttle_expo * tt_reg;
    end

    // stage 3: reciprocal product for /2500, upper bits of expo*t*t/(y*y)
    always_comb
    begin
        logic [22:0] r;
        logic [22:0] dsh;
        pm_next  = p_reg[21:0] * RECIP_2500;
        r        = num_reg;
        qhi_next = '0;
        for (int b = 6; b >= 3; b--)
        begin
            dsh = 23'(yy_reg[2]) << b;
            if (r >= dsh)
            begin
                r           = r - dsh;
                qhi_next[b] = 1'b1;
            end
        end
        rem_next = r;
    end

    // stage 4: pitch/roll value, lower quotient bits
    always_comb
    begin
        logic [22:0] r;
        logic [22:0] dsh;
        pv_next = ppos_reg ? pm_reg[43:33] : '0;
        r       = rem_reg;
        q_next  = qhi_reg;
        for (int b = 2; b >= 0; b--)
        begin
            dsh = 23'(yy_reg[3]) << b;
            if (r >= dsh)
            begin
                r         = r - dsh;
                q_next[b] = 1'b1;
            end
        end
    end

    // stage 5: t * inner
    always_comb
    begin
        logic signed [8:0] inner;
        inner  = 9'sd100 - $signed({2'b0, cfg.throttle_expo}) + $signed({2'b0, q_reg});
        x_next = t_reg[4] * inner;
    end

    // stage 6: magnitude times reciprocal of 10
    always_comb
    begin
        logic [17:0] ax;
        ax      = (x_reg < 18'sd0) ? 18'(-x_reg) : x_reg;
        xm_next = ax[13:0] * RECIP_10;
    end

    // stage 7: curve value v
    always_comb
    begin
        logic [10:0]        d;
        logic [10:0]        mid10;
        logic signed [12:0] sd;
        d      = xm_reg[27:17];
        sd     = xneg_reg ? -$signed({2'b0, d}) : $signed({2'b0, d});
        mid10  = 11'(cfg.throttle_middle * 11'd10);
        v_next = $signed({2'b0, mid10}) + sd;
    end

    // stage 8: span * v
    always_comb
    begin
        logic signed [12:0] span;
        span   = $signed({1'b0, cfg.throttle_ceiling}) - $signed({1'b0, cfg.throttle_floor});
        w_next = span * v_reg;
    end

    // stage 9: magnitude times reciprocal of 1000
    always_comb
    begin
        logic [25:0] aw;
        aw      = (w_reg < 26'sd0) ? 26'(-w_reg) : w_reg;
        wm_next = aw[23:0] * RECIP_1000;
    end

    // stage 10: offset from floor, clamp, select
    always_comb
    begin
        logic [14:0]        dq;
        logic signed [16:0] r;
        logic [11:0]        thr;
        dq = wm_reg[48:34];
        r  = $signed({5'b0, cfg.throttle_floor})
             + (wneg_reg ? -$signed({2'b0, dq}) : $signed({2'b0, dq}));
        if (r < 17'sd0)
        begin
            thr = '0;
        end
        else if (r > $signed({5'b0, VALUE_MAX}))
        begin
            thr = VALUE_MAX;
        end
        else
        begin
            thr = r[11:0];
        end
        if (err_reg[LAST-1])
        begin
            curve_next = '0;
        end
        else if (req_type_t'(typ_reg[LAST-1]) == REQ_THROTTLE)
        begin
            curve_next = thr;
        end
        else
        begin
            curve_next = {1'b0, pv_reg[9]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            typ_reg[0] <= req_type;
            err_reg[0] <= err_next;
            base_reg   <= base_next;
            i3_reg     <= point_index[2:0];
            t_reg[0]   <= t_next;
            y_reg      <= y_next;
        end
        for (int k = 1; k < LAST; k++)
        begin
            if (adv[k])
            begin
                typ_reg[k] <= typ_reg[k-1];
            end
        end
        for (int k = 1; k <= LAST; k++)
        begin
            if (adv[k])
            begin
                err_reg[k] <= err_reg[k-1];
            end
        end
        for (int k = 1; k <= 4; k++)
        begin
            if (adv[k])
            begin
                t_reg[k] <= t_reg[k-1];
            end
        end
        if (adv[1])
        begin
            pb_reg    <= pb_next;
            tt_reg    <= tt_next;
            yy_reg[1] <= yy_next;
        end
        if (adv[2])
        begin
            p_reg     <= p_next;
            num_reg   <= num_next;
            yy_reg[2] <= yy_reg[1];
        end
        if (adv[3])
        begin
            ppos_reg  <= p_reg > 26'sd0;
            pm_reg    <= pm_next;
            rem_reg   <= rem_next;
            qhi_reg   <= qhi_next;
            yy_reg[3] <= yy_reg[2];
        end
        if (adv[4])
        begin
            pv_reg[4] <= pv_next;
            q_reg     <= q_next;
        end
        for (int k = 5; k <= 9; k++)
        begin
            if (adv[k])
            begin
                pv_reg[k] <= pv_reg[k-1];
            end
        end
        if (adv[5])
        begin
            x_reg <= x_next;
        end
        if (adv[6])
        begin
            xneg_reg <= x_reg < 18'sd0;
            xm_reg   <= xm_next;
        end
        if (adv[7])
        begin
            v_reg <= v_next;
        end
        if (adv[8])
        begin
            w_reg <= w_next;
        end
        if (adv[9])
        begin
            wneg_reg <= w_reg < 26'sd0;
            wm_reg   <= wm_next;
        end
        if (adv[LAST])
        begin
            curve_reg <= curve_next;
        end
    end

endmodule

FILE: hdl/rc_expo_curve_point.sv
// Top level of the stick and throttle curve breakpoint calculator
// Usage:
//   Request channel (req_valid/req_stall, req_type, point_index): one breakpoint
//   request per transfer; req_type selects the pitch/roll or the throttle curve.
//   Response channel (rsp_valid/rsp_stall, curve_value, index_error): one result
//   per request, in request order. An index past the selected curve returns 0
//   with index_error set.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is always
//   high; write only while no request is in flight. Unknown indexes are dropped.
//   One request is taken every cycle while req_stall is low. The pipe is eleven
//   register stages, each stage holds at most three multiplies and four steps
//   of the expo*t*t/(y*y) restoring divide.
//   When the receiver stalls, stages fill up behind the output register;
//   req_stall rises only once all eleven stages hold an item.
//   Reset empties the pipe and loads the default curve settings.
`timescale 1ns / 1ps

module rc_expo_curve_point
    import rcx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic                   req_type,
    input  logic [3:0]             point_index,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [11:0]            curve_value,
    output logic                   index_error,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STICK_EXPO:       cfg_next.stick_expo       = cfg_data[6:0];
                CFG_STICK_RATE:       cfg_next.stick_rate       = cfg_data[7:0];
                CFG_THROTTLE_MIDDLE:  cfg_next.throttle_middle  = cfg_data[6:0];
                CFG_THROTTLE_EXPO:    cfg_next.throttle_expo    = cfg_data[6:0];
                CFG_THROTTLE_FLOOR:   cfg_next.throttle_floor   = cfg_data;
                CFG_THROTTLE_CEILING: cfg_next.throttle_ceiling = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_expo       <= RST_STICK_EXPO;
            cfg_reg.stick_rate       <= RST_STICK_RATE;
            cfg_reg.throttle_middle  <= RST_THROTTLE_MIDDLE;
            cfg_reg.throttle_expo    <= RST_THROTTLE_EXPO;
            cfg_reg.throttle_floor   <= RST_THROTTLE_FLOOR;
            cfg_reg.throttle_ceiling <= RST_THROTTLE_CEILING;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rcx_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .point_index (point_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .curve_value (curve_value),
        .index_error (index_error)
    );

endmodule

FILE: hdl/rcx_checker.sv
// Port-level checks for rc_expo_curve_point, bound to the top level
`timescale 1ns / 1ps
`include "rc_expo_curve_point_macros.svh"

module rcx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [11:0] curve_value,
    input logic        index_error,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    `RCX_ASSERT_NOW(a_err_zero, rsp_valid && index_error, curve_value == 12'd0, "error result with nonzero value")
    `RCX_ASSERT_NOW(a_stall_src, req_stall, rsp_valid && rsp_stall, "request stalled while output drains")
    `RCX_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")
    `RCX_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(curve_value) && $stable(index_error), "stalled response changed")

endmodule

bind rc_expo_curve_point rcx_checker u_rcx_checker (.*);

FILE: verif/rc_expo_curve_point_checker.sv
// Checker for rc_expo_curve_point: predicts curve points and compares responses
`timescale 1ns / 1ps

module rc_expo_curve_point_checker
    import rcx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_stall,
    input  logic                   req_type,
    input  logic [3:0]             point_index,
    input  logic                   rsp_valid,
    input  logic                   rsp_stall,
    input  logic [11:0]            curve_value,
    input  logic                   index_error,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending_count,
    output int                     rsp_count
);

    typedef struct packed {
        logic [11:0] value;
        logic        err;
    } curve_point_t;

    cfg_t         curve_cfg;
    curve_point_t expected_points[$];

    function automatic curve_point_t curve_point(req_type_t kind, logic [3:0] idx);
        curve_point_t r;
        int i;
        int base;
        int v;
        int t;
        int y;
        int inner;
        i = int'(idx);
        r.err = 1'b0;
        if ((kind == REQ_PITCH_ROLL && idx > PITCH_LAST) ||
            (kind == REQ_THROTTLE && idx > THROTTLE_LAST))
        begin
            r.err = 1'b1;
            r.value = '0;
            return r;
        end
        if (kind == REQ_PITCH_ROLL)
        begin
            base = 2500 + int'(curve_cfg.stick_expo) * (i * i - 25);
            v = base * i * int'(curve_cfg.stick_rate) / 2500;
        end
        else
        begin
            t = 10 * i - int'(curve_cfg.throttle_middle);
            y = 1;
            if (t > 0) y = 100 - int'(curve_cfg.throttle_middle);
            if (t < 0) y = int'(curve_cfg.throttle_middle);
            if (y < 1) y = 1;
            inner = 100 - int'(curve_cfg.throttle_expo)
                + int'(curve_cfg.throttle_expo) * (t * t) / (y * y);
            v = 10 * int'(curve_cfg.throttle_middle) + t * inner / 10;
            v = int'(curve_cfg.throttle_floor)
                + (int'(curve_cfg.throttle_ceiling) - int'(curve_cfg.throttle_floor))
                * v / 1000;
        end
        if (v < 0) r.value = '0;
        else if (v > 4095) r.value = VALUE_MAX;
        else r.value = v[11:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_point_t got;
        curve_point_t want;
        if (!rst_n)
        begin
            curve_cfg <= '{RST_STICK_EXPO, RST_STICK_RATE, RST_THROTTLE_MIDDLE,
                           RST_THROTTLE_EXPO, RST_THROTTLE_FLOOR, RST_THROTTLE_CEILING};
            expected_points.delete();
            fail_count <= 0;
            pending_count <= 0;
            rsp_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_STICK_EXPO:       curve_cfg.stick_expo <= cfg_data[6:0];
                    CFG_STICK_RATE:       curve_cfg.stick_rate <= cfg_data[7:0];
                    CFG_THROTTLE_MIDDLE:  curve_cfg.throttle_middle <= cfg_data[6:0];
                    CFG_THROTTLE_EXPO:    curve_cfg.throttle_expo <= cfg_data[6:0];
                    CFG_THROTTLE_FLOOR:   curve_cfg.throttle_floor <= cfg_data;
                    CFG_THROTTLE_CEILING: curve_cfg.throttle_ceiling <= cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
                expected_points.push_back(curve_point(req_type_t'(req_type), point_index));
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count <= rsp_count + 1;
                got = '{curve_value, index_error};
                if (expected_points.size() == 0)
                begin
                    $error("response transfer with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.value !== want.value)
                        $error("curve_value expected %0d actual %0d", want.value, got.value);
                    if (got.err !== want.err)
                        $error("index_error expected %0d actual %0d", want.err, got.err);
                    if (got !== want)
                        fail_count <= fail_count + 1;
                end
            end
            pending_count <= expected_points.size();
        end
    end

endmodule

FILE: verif/rc_expo_curve_point_test.sv
// Testbench top for rc_expo_curve_point: stimulus, configuration phases, verdict
`timescale 1ns / 1ps

module rc_expo_curve_point_test;
    import rcx_pkg::*;

    localparam int LATENCY     = NUM_STAGES;
    localparam int CYCLE_LIMIT = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    logic                   req_type;
    logic [3:0]             point_index;
    logic                   rsp_valid;
    logic                   rsp_stall;
    logic [11:0]            curve_value;
    logic                   index_error;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending_count;
    int                     rsp_count;
    int                     cycle_count;
    int                     sent_count;
    bit                     calm_mode;
    bit                     hold_rsp;

    rc_expo_curve_point u_dut (.*);

    rc_expo_curve_point_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, a long hold-off on request, none in calm stretches
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= hold_rsp || (!calm_mode && $urandom_range(99) < 15);
    end

    task automatic send_point(req_type_t kind, logic [3:0] idx);
        if (!calm_mode)
            while ($urandom_range(99) < 15)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid   <= 1'b1;
        req_type    <= kind;
        point_index <= idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic drain_pipe();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_all(int se, int sr, int tm, int te, int tf, int tc);
        write_reg(CFG_STICK_EXPO, 12'(se));
        write_reg(CFG_STICK_RATE, 12'(sr));
        write_reg(CFG_THROTTLE_MIDDLE, 12'(tm));
        write_reg(CFG_THROTTLE_EXPO, 12'(te));
        write_reg(CFG_THROTTLE_FLOOR, 12'(tf));
        write_reg(CFG_THROTTLE_CEILING, 12'(tc));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic sweep_all();
        for (int i = 0; i < 16; i++)
        begin
            send_point(REQ_PITCH_ROLL, 4'(i));
            send_point(REQ_THROTTLE, 4'(i));
        end
    endtask

    initial
    begin
        cycle_count = 0;
        sent_count  = 0;
        calm_mode   = 1'b0;
        hold_rsp    = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_type    = 1'b0;
        point_index = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, every index of both curves incl. out of range
        sweep_all();
        drain_pipe();
        // extremes: expo above range drives negative results, floor above ceiling
        write_all(127, 255, 0, 127, 4095, 0);
        sweep_all();
        drain_pipe();
        write_all(0, 0, 100, 100, 0, 4095);
        sweep_all();
        drain_pipe();

        // long receiver hold-off while sender keeps offering, pipe must back up
        fork
            begin
                hold_rsp = 1'b1;
                repeat (60) @(posedge clk);
                hold_rsp = 1'b0;
            end
            for (int k = 0; k < 40; k++)
                send_point(req_type_t'($urandom_range(1)), 4'($urandom_range(15)));
        join
        drain_pipe();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_all($urandom_range(127), $urandom_range(255), $urandom_range(127),
                      $urandom_range(127), $urandom_range(4095), $urandom_range(4095));
            calm_mode = (phase == 2);
            for (int k = 0; k < 280; k++)
            begin
                // mostly in-range indexes, a few beyond the curve
                if ($urandom_range(9) == 0)
                    send_point(req_type_t'($urandom_range(1)), 4'($urandom_range(15)));
                else if ($urandom_range(1))
                    send_point(REQ_THROTTLE, 4'($urandom_range(10)));
                else
                    send_point(REQ_PITCH_ROLL, 4'($urandom_range(5)));
            end
            calm_mode = 1'b0;
            drain_pipe();
        end

        $display("Sent %0d curve point requests, %0d responses over 9 settings,",
                 sent_count, rsp_count);
        $display("including register extremes, index errors and full-pipe backpressure.");
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
